// ===== design/hdlc_pkg.sv =====
`timescale 1ns / 1ps

package hdlc_pkg;

   // Line control bytes
   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;

   // FCS-16, reflected form
   localparam logic [15:0] FCS_POLY = 16'h8408;
   localparam logic [15:0] FCS_INIT = 16'hFFFF;

   // Largest expansion of one payload byte
   localparam int MAX_OUT = 8;

   typedef logic [MAX_OUT-1:0][7:0] byte_list_type;

   // One byte through the FCS register, LSB first
   function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
      logic [15:0] v;
      v = fcs ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (v[0]) begin
            v = (v >> 1) ^ FCS_POLY;
         end else begin
            v = v >> 1;
         end
      end
      return v;
   endfunction

   // Bytes that must be escaped on the line
   function automatic logic needs_escape(input logic [7:0] b);
      return (b == ESC_BYTE) || (b == FLAG_BYTE);
   endfunction

endpackage

// ===== design/hdlc_byte_stuff_framer_fcs16.sv =====
`timescale 1ns / 1ps

// Channel  Dir  tdata           tlast      Meaning
// req      in   data_byte[7:0]  last_byte  raw payload byte of a packet
// rsp      out  out_byte[7:0]   run_end    framed line byte
//
// A payload byte yields 1 to 8 line bytes (2 for a stuffed mid-frame byte), and an item
// holds the output until its last line byte is accepted. The input and expansion registers
// sit in series ahead of rsp; items flow every cycle only while each yields one byte and
// rsp is ready, since a stall on rsp holds the current item and the input behind it.
// Reset is synchronous, active high: it empties both registers, closes the frame and
// loads the FCS with its initial value. Stalls on rsp hold the current byte stable.
module hdlc_byte_stuff_framer_fcs16 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // run_end
);

   // Input register
   logic       a_valid_ff, a_valid_in;
   logic [7:0] a_data_ff;
   logic       a_last_ff;

   // Expansion register: line bytes of one item and a read pointer
   logic                   b_valid_ff, b_valid_in;
   hdlc_pkg::byte_list_type b_bytes_ff, b_bytes_in;
   logic [2:0]             b_end_ff, b_end_in;
   logic [2:0]             b_idx_ff, b_idx_in;

   // Framer state
   logic        in_frame_ff, in_frame_in;
   logic [15:0] fcs_ff, fcs_in;

   logic b_done;
   logic a_to_b;
   logic take_req;

   // Expansion scratch
   hdlc_pkg::byte_list_type list;
   logic [3:0]  pos;
   logic [15:0] fcs_next;
   logic [15:0] fcs_out;
   logic [2:0][7:0] cand;

   // Handshakes
   assign b_done     = b_valid_ff && rsp_tready && (b_idx_ff == b_end_ff);
   assign a_to_b     = a_valid_ff && (!b_valid_ff || b_done);
   assign req_tready = !a_valid_ff || a_to_b;
   assign take_req   = req_tvalid && req_tready;

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = b_bytes_ff[b_idx_ff];
   assign rsp_tlast  = (b_idx_ff == b_end_ff);

   // Expand one payload byte into its line bytes
   always_comb begin
      list     = '0;
      pos      = '0;
      fcs_next = hdlc_pkg::fcs_update(fcs_ff, a_data_ff);
      fcs_out  = ~fcs_next;
      cand[0]  = a_data_ff;
      cand[1]  = fcs_out[15:8];
      cand[2]  = fcs_out[7:0];
      if (!in_frame_ff) begin
         list[pos[2:0]] = hdlc_pkg::FLAG_BYTE;
         pos = pos + 4'd1;
      end
      for (int k = 0; k < 3; k++) begin
         if (k == 0 || a_last_ff) begin
            if (hdlc_pkg::needs_escape(cand[k])) begin
               list[pos[2:0]] = hdlc_pkg::ESC_BYTE;
               pos = pos + 4'd1;
               list[pos[2:0]] = cand[k] ^ hdlc_pkg::ESC_BYTE;
            end else begin
               list[pos[2:0]] = cand[k];
            end
            pos = pos + 4'd1;
         end
      end
      if (a_last_ff) begin
         list[pos[2:0]] = hdlc_pkg::FLAG_BYTE;
         pos = pos + 4'd1;
      end
   end

   // Next values
   always_comb begin
      a_valid_in  = a_valid_ff;
      b_valid_in  = b_valid_ff;
      b_bytes_in  = b_bytes_ff;
      b_end_in    = b_end_ff;
      b_idx_in    = b_idx_ff;
      in_frame_in = in_frame_ff;
      fcs_in      = fcs_ff;

      if (a_to_b) begin
         a_valid_in = 1'b0;
      end
      if (take_req) begin
         a_valid_in = 1'b1;
      end

      if (b_valid_ff && rsp_tready) begin
         b_idx_in = b_idx_ff + 3'd1;
      end
      if (b_done) begin
         b_valid_in = 1'b0;
      end

      if (a_to_b) begin
         b_valid_in = 1'b1;
         b_bytes_in = list;
         b_end_in   = pos[2:0] - 3'd1;
         b_idx_in   = '0;
         if (a_last_ff) begin
            in_frame_in = 1'b0;
            fcs_in      = hdlc_pkg::FCS_INIT;
         end else begin
            in_frame_in = 1'b1;
            fcs_in      = fcs_next;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         b_idx_ff    <= '0;
         in_frame_ff <= 1'b0;
         fcs_ff      <= hdlc_pkg::FCS_INIT;
      end else begin
         a_valid_ff  <= a_valid_in;
         b_valid_ff  <= b_valid_in;
         b_idx_ff    <= b_idx_in;
         in_frame_ff <= in_frame_in;
         fcs_ff      <= fcs_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (take_req) begin
         a_data_ff <= req_tdata;
         a_last_ff <= req_tlast;
      end
      b_bytes_ff <= b_bytes_in;
      b_end_ff   <= b_end_in;
   end

   // Read pointer never runs past the end of the list
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (b_idx_ff <= b_end_ff))
      else $error("read pointer past end of line bytes");

   // A closed frame always holds the initial FCS
   a_fcs_idle: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (fcs_ff == hdlc_pkg::FCS_INIT))
      else $error("FCS not reset outside a frame");

   // Opening a frame puts the flag first
   a_open_flag: assert property (@(posedge clock) disable iff (reset)
      (a_to_b && !in_frame_ff) |=> (b_bytes_ff[0] == hdlc_pkg::FLAG_BYTE))
      else $error("frame opened without flag");

   // Last payload byte closes the frame, ending in a flag
   a_close: assert property (@(posedge clock) disable iff (reset)
      (a_to_b && a_last_ff) |=>
         (!in_frame_ff && (b_bytes_ff[b_end_ff] == hdlc_pkg::FLAG_BYTE)))
      else $error("frame not closed after last byte");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// One line byte as the framer should emit it
typedef struct packed {
   logic [7:0] value;
   logic       run_end;
} line_byte_type;

// Scoreboard: tracks framing and FCS state, holds the line bytes still to come
class line_scoreboard;
   line_byte_type line_q[$];
   bit          frame_open;
   logic [15:0] fcs_acc;
   int          errors;

   function new();
      frame_open = 0;
      fcs_acc    = hdlc_pkg::FCS_INIT;
      errors     = 0;
   endfunction

   // Reflected CRC-16, one byte, LSB first
   function logic [15:0] fcs16_step(logic [15:0] crc, logic [7:0] d);
      logic [15:0] r;
      r = crc ^ {8'h00, d};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ hdlc_pkg::FCS_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function bit is_special(logic [7:0] d);
      return (d == hdlc_pkg::ESC_BYTE) || (d == hdlc_pkg::FLAG_BYTE);
   endfunction

   // Prints one line and counts it
   task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   // Searches a closing payload byte whose FCS needs stuffing
   function bit find_fcs_escape(output logic [7:0] pick);
      logic [15:0] start;
      logic [15:0] f;
      start = frame_open ? fcs_acc : hdlc_pkg::FCS_INIT;
      pick  = 8'h00;
      for (int i = 0; i < 256; i++) begin
         f = ~fcs16_step(start, i[7:0]);
         if (is_special(f[15:8]) || is_special(f[7:0])) begin
            pick = i[7:0];
            return 1;
         end
      end
      return 0;
   endfunction

   // Accepted payload transaction: predict the line bytes it causes
   function void note_payload(logic [7:0] d, logic is_last);
      logic [7:0]  buf_b[16];
      int          n;
      logic [15:0] f;
      logic [7:0]  stuff[3];
      line_byte_type e;
      n = 0;
      if (!frame_open) begin
         buf_b[n++] = hdlc_pkg::FLAG_BYTE;
         frame_open = 1;
         fcs_acc    = hdlc_pkg::FCS_INIT;
      end
      fcs_acc  = fcs16_step(fcs_acc, d);
      f        = ~fcs_acc;
      stuff[0] = d;
      stuff[1] = f[15:8];
      stuff[2] = f[7:0];
      for (int k = 0; k < (is_last ? 3 : 1); k++) begin
         if (is_special(stuff[k])) begin
            buf_b[n++] = hdlc_pkg::ESC_BYTE;
            buf_b[n++] = stuff[k] ^ hdlc_pkg::ESC_BYTE;
         end else begin
            buf_b[n++] = stuff[k];
         end
      end
      if (is_last) begin
         buf_b[n++] = hdlc_pkg::FLAG_BYTE;
         frame_open = 0;
         fcs_acc    = hdlc_pkg::FCS_INIT;
      end
      for (int k = 0; k < n; k++) begin
         e.value   = buf_b[k];
         e.run_end = (k == n - 1);
         line_q.insert(line_q.size(), e);
      end
   endfunction

   // Accepted line transaction: compare with the oldest prediction
   task check_line_byte(logic [7:0] v, logic re);
      line_byte_type e;
      if (line_q.size() == 0) begin
         report($sformatf("unexpected line byte %02h run_end %0b", v, re));
         return;
      end
      e = line_q.pop_front();
      if (v !== e.value)
         report($sformatf("out_byte %02h, expected %02h", v, e.value));
      if (re !== e.run_end)
         report($sformatf("run_end %0b, expected %0b (byte %02h)", re, e.run_end, e.value));
   endtask
endclass

module tb;
   localparam int IDLE_LIMIT = 2000;
   localparam int TAIL_CYCLES = 30;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] data_byte
   logic       req_tlast;   // last_byte
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [7:0] out_byte
   logic       rsp_tlast;   // run_end

   line_scoreboard sb = new();
   bit tx_calm = 0;
   bit rx_calm = 0;
   int idle_cycles = 0;
   int items_sent = 0;

   hdlc_byte_stuff_framer_fcs16 dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   // Clock
   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Gap before a transaction; calm stretches run without idling
   function int tx_gap();
      if ($urandom_range(0, 24) == 0) tx_calm = ~tx_calm;
      return tx_calm ? 0 : $urandom_range(0, 19);
   endfunction

   function int rx_gap();
      if ($urandom_range(0, 39) == 0) rx_calm = ~rx_calm;
      return rx_calm ? 0 : $urandom_range(0, 19);
   endfunction

   // One payload transaction; valid stays high across back-to-back items
   task send_payload(input logic [7:0] d, input logic is_last);
      int gap;
      gap = tx_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      sb.note_payload(d, is_last);
      items_sent++;
   endtask

   // Packet closed by a byte whose FCS needs stuffing, if one exists
   task send_fcs_escape_tail();
      logic [7:0] pick;
      if (sb.find_fcs_escape(pick))
         send_payload(pick, 1'b1);
      else
         send_payload(8'h55, 1'b1);
   endtask

   // Random payload byte, weighted toward the stuffed values
   function logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return hdlc_pkg::FLAG_BYTE;
         1: return hdlc_pkg::ESC_BYTE;
         2: return ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Line side: random backpressure, check each accepted byte
   initial begin
      int gap;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         gap = rx_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_line_byte(rsp_tdata, rsp_tlast);
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      int len;
      logic [7:0] d;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'h00;
      req_tlast  <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Single-byte packets: flag, payload, FCS and flag in one go
      send_payload(8'h00, 1'b1);
      send_payload(8'hFF, 1'b1);
      send_payload(hdlc_pkg::ESC_BYTE, 1'b1);
      send_payload(hdlc_pkg::FLAG_BYTE, 1'b1);
      // Longer packet with stuffed bytes and their XOR images
      send_payload(hdlc_pkg::FLAG_BYTE, 1'b0);
      send_payload(hdlc_pkg::ESC_BYTE, 1'b0);
      send_payload(8'h03, 1'b0);
      send_payload(8'h5E, 1'b0);
      send_payload(8'h5D, 1'b0);
      send_payload(8'h00, 1'b0);
      send_payload(8'hFF, 1'b0);
      send_payload(hdlc_pkg::FLAG_BYTE, 1'b1);
      // FCS bytes that need stuffing
      send_fcs_escape_tail();
      send_payload(8'hA5, 1'b0);
      send_payload(8'h5A, 1'b0);
      send_fcs_escape_tail();
      send_payload(8'h01, 1'b0);
      send_fcs_escape_tail();

      // Random packets, mostly short, a few long
      while (items_sent < 220) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
         for (int j = 0; j < len; j++) begin
            if (j == len - 1 && $urandom_range(0, 5) == 0) begin
               send_fcs_escape_tail();
            end else begin
               d = pick_byte();
               send_payload(d, j == len - 1);
            end
         end
      end
      req_tvalid <= 1'b0;

      // Drain, then let the block settle
      while (sb.line_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.line_q.size() != 0)
         sb.report($sformatf("%0d line bytes never arrived", sb.line_q.size()));
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
